FILE: src/dsteq_pkg.sv
// ----------------------------------------------------------------------------
// dsteq_pkg
// shared types and constants of the dual sorted timer event queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsteq_pkg;

   // fixed field widths of the request and response beats
   localparam int OPCODE_W = 2;
   localparam int TASK_W   = 10;
   localparam int TIME_W   = 48;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_POOL_EMPTY  = 2'd1,
      STAT_QUEUE_EMPTY = 2'd2,
      STAT_NOT_FOUND   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_FREE,
      S_INS_LINK,
      S_INS_WALK,
      S_INS_PLACE,
      S_INS_FIX,
      S_HEAD,
      S_POP_TAKE,
      S_REM_WALK,
      S_REM_UNLINK,
      S_REM_FREE,
      S_CLR_TAKE,
      S_DONE
   } state_type;

   // what the shared compare unit tests
   typedef enum logic {
      CMP_TIME_GE,
      CMP_TASK_EQ
   } cmp_mode_type;

   // entry memory write command
   typedef struct packed {
      logic en;   // write the link of the entry
      logic all;  // also write task and wake time
   } mem_wr_type;

endpackage

FILE: src/dsteq_if.sv
// ----------------------------------------------------------------------------
// dsteq channel interfaces
// valid/ready channels for command beats and response beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dsteq_req_if;
   logic                          valid;
   logic                          ready;
   logic [dsteq_pkg::OPCODE_W-1:0] opcode;
   logic                          queue_select;
   logic [dsteq_pkg::TASK_W-1:0]   task_id;
   logic [dsteq_pkg::TIME_W-1:0]   wake_time;

   modport source (output valid, output opcode, output queue_select,
                   output task_id, output wake_time, input ready);
   modport sink   (input valid, input opcode, input queue_select,
                   input task_id, input wake_time, output ready);
endinterface

interface dsteq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dsteq_pkg::STATUS_W-1:0] status;
   logic [dsteq_pkg::TASK_W-1:0]   out_task_id;
   logic [dsteq_pkg::TIME_W-1:0]   out_wake_time;

   modport source (output valid, output status, output out_task_id,
                   output out_wake_time, input ready);
   modport sink   (input valid, input status, input out_task_id,
                   input out_wake_time, output ready);
endinterface

FILE: src/dsteq_entry_mem.sv
// ----------------------------------------------------------------------------
// dsteq_entry_mem
// entry pool storage: wake time, task id and link, one read and one write port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsteq_entry_mem #(
   parameter int POOL_SIZE    = 16,
   parameter int TASK_ID_BITS = 10,
   localparam int ADDR_W      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1,
   localparam int LINK_W      = $clog2(POOL_SIZE + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic [dsteq_pkg::TIME_W-1:0]        rd_time,
   output logic [TASK_ID_BITS-1:0]             rd_task,
   output logic [LINK_W-1:0]                   rd_link,
   input  dsteq_pkg::mem_wr_type               wr_ctl,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic [LINK_W-1:0]                   wr_link,
   input  logic [TASK_ID_BITS-1:0]             wr_task,
   input  logic [dsteq_pkg::TIME_W-1:0]        wr_time
);

   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

   logic [dsteq_pkg::TIME_W-1:0] time_mem [POOL_SIZE];
   logic [TASK_ID_BITS-1:0]      task_mem [POOL_SIZE];
   logic [LINK_W-1:0]            link_mem [POOL_SIZE];
   logic [POOL_SIZE-1:0]         link_vld_ff;
   logic [LINK_W-1:0]            link_rst;

   // an unwritten link reads as the reset free chain: i -> i-1, entry 0 -> null
   assign link_rst = (rd_addr == '0) ? NIL : (LINK_W'(rd_addr) - LINK_W'(1));

   always_ff @(posedge clock) begin
      if (wr_ctl.en) begin
         link_mem[wr_addr] <= wr_link;
         if (wr_ctl.all) begin
            task_mem[wr_addr] <= wr_task;
            time_mem[wr_addr] <= wr_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (wr_ctl.en) begin
         link_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_time <= time_mem[rd_addr];
      rd_task <= task_mem[rd_addr];
      rd_link <= link_vld_ff[rd_addr] ? link_mem[rd_addr] : link_rst;
   end

endmodule

FILE: src/dsteq_cmp_unit.sv
// ----------------------------------------------------------------------------
// dsteq_cmp_unit
// shared compare unit: wake time order for insert, task match for remove
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsteq_cmp_unit #(
   parameter int TASK_ID_BITS = 10
) (
   input  dsteq_pkg::cmp_mode_type        mode,
   input  logic [dsteq_pkg::TIME_W-1:0]   key_time,
   input  logic [TASK_ID_BITS-1:0]        key_task,
   input  logic [dsteq_pkg::TIME_W-1:0]   ent_time,
   input  logic [TASK_ID_BITS-1:0]        ent_task,
   output logic                           hit
);

   always_comb begin
      case (mode)
         dsteq_pkg::CMP_TIME_GE: hit = (key_time >= ent_time);
         dsteq_pkg::CMP_TASK_EQ: hit = (key_task == ent_task);
         default:                hit = 1'b0;
      endcase
   end

endmodule

FILE: src/dual_sorted_timer_event_queue_core.sv
// ----------------------------------------------------------------------------
// dual_sorted_timer_event_queue_core
// insert walks the target queue (no walk on an exhausted pool), pop takes the
//   head (or reports an empty queue), remove walks both queues and unlinks the
//   first match in each, clear frees every queued entry
// one command beat at a time; the walk does one entry per cycle through the
//   single read port of the entry memory
// reset: synchronous, both queues empty, every entry on the free list; no
//   clearing pass, unwritten links read as the free chain through valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_sorted_timer_event_queue_core #(
   parameter int POOL_SIZE    = 16,
   parameter int TASK_ID_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   dsteq_req_if.sink         req_chan,
   dsteq_rsp_if.source       rsp_chan
);

   localparam int ADDR_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int LINK_W     = $clog2(POOL_SIZE + 1);
   localparam int TIME_W     = dsteq_pkg::TIME_W;
   localparam int OUT_TASK_W = dsteq_pkg::TASK_W;
   // index POOL_SIZE marks the end of a list
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);

   // sequencer state
   dsteq_pkg::state_type   state_ff, state_in;
   dsteq_pkg::op_type      op_ff, op_in;
   logic                   wq_ff, wq_in;         // queue being walked: 0 sleep, 1 sync
   logic [TASK_ID_BITS-1:0] task_key_ff, task_key_in;
   logic [TIME_W-1:0]      time_key_ff, time_key_in;
   logic [LINK_W-1:0]      cur_ff, cur_in;
   logic [LINK_W-1:0]      prev_ff, prev_in;
   logic [LINK_W-1:0]      new_ff, new_in;       // entry taken from the free list
   logic [LINK_W-1:0]      next_ff, next_in;     // successor of a matched entry
   logic                   found_ff, found_in;

   // list heads
   logic [LINK_W-1:0]      sleep_first_ff, sleep_first_in;
   logic [LINK_W-1:0]      sync_first_ff, sync_first_in;
   logic [LINK_W-1:0]      free_first_ff, free_first_in;

   // result being built and the response output register
   dsteq_pkg::status_type  res_status_ff, res_status_in;
   logic [OUT_TASK_W-1:0]  res_task_ff, res_task_in;
   logic [TIME_W-1:0]      res_time_ff, res_time_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dsteq_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [OUT_TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic [TIME_W-1:0]      rsp_time_ff, rsp_time_in;

   // entry memory and compare unit hookup
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [TIME_W-1:0]       mem_rd_time;
   logic [TASK_ID_BITS-1:0] mem_rd_task;
   logic [LINK_W-1:0]       mem_rd_link;
   dsteq_pkg::mem_wr_type   mem_wr;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [LINK_W-1:0]       mem_wr_link;
   dsteq_pkg::cmp_mode_type cmp_mode;
   logic                    cmp_hit;

   logic                   head_wr;
   logic [LINK_W-1:0]      head_val;
   logic [LINK_W-1:0]      head_q;
   logic                   req_fire;
   dsteq_pkg::status_type  end_status;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign head_q   = wq_ff ? sync_first_ff : sleep_first_ff;
   // a remove that matched in neither queue reports not found
   assign end_status = (op_ff == dsteq_pkg::OP_REMOVE && !found_ff) ?
                       dsteq_pkg::STAT_NOT_FOUND : dsteq_pkg::STAT_OK;

   assign req_chan.ready         = (state_ff == dsteq_pkg::S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.out_task_id   = rsp_task_ff;
   assign rsp_chan.out_wake_time = rsp_time_ff;

   dsteq_entry_mem #(
      .POOL_SIZE    (POOL_SIZE),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_entry_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .rd_time (mem_rd_time),
      .rd_task (mem_rd_task),
      .rd_link (mem_rd_link),
      .wr_ctl  (mem_wr),
      .wr_addr (mem_wr_addr),
      .wr_link (mem_wr_link),
      .wr_task (task_key_ff),
      .wr_time (time_key_ff)
   );

   dsteq_cmp_unit #(
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_cmp_unit (
      .mode     (cmp_mode),
      .key_time (time_key_ff),
      .key_task (task_key_ff),
      .ent_time (mem_rd_time),
      .ent_task (mem_rd_task),
      .hit      (cmp_hit)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dsteq_pkg::S_IDLE;
         sleep_first_ff <= NIL;
         sync_first_ff  <= NIL;
         free_first_ff  <= LINK_W'(POOL_SIZE - 1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sleep_first_ff <= sleep_first_in;
         sync_first_ff  <= sync_first_in;
         free_first_ff  <= free_first_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      wq_ff         <= wq_in;
      task_key_ff   <= task_key_in;
      time_key_ff   <= time_key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      new_ff        <= new_in;
      next_ff       <= next_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      res_time_ff   <= res_time_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_time_ff   <= rsp_time_in;
   end

   // sequencer: next state, memory commands and list head updates
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      wq_in         = wq_ff;
      task_key_in   = task_key_ff;
      time_key_in   = time_key_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      new_in        = new_ff;
      next_in       = next_ff;
      found_in      = found_ff;
      free_first_in = free_first_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      res_time_in   = res_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_time_in   = rsp_time_ff;
      mem_rd_addr   = cur_ff[ADDR_W-1:0];
      mem_wr        = '0;
      mem_wr_addr   = cur_ff[ADDR_W-1:0];
      mem_wr_link   = free_first_ff;
      cmp_mode      = dsteq_pkg::CMP_TIME_GE;
      head_wr       = 1'b0;
      head_val      = NIL;

      case (state_ff)
         dsteq_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in         = dsteq_pkg::op_type'(req_chan.opcode);
               task_key_in   = TASK_ID_BITS'(req_chan.task_id);
               time_key_in   = req_chan.wake_time;
               found_in      = 1'b0;
               res_status_in = dsteq_pkg::STAT_OK;
               res_task_in   = '0;
               res_time_in   = '0;
               // remove and clear go through sleep first, then sync
               if (op_in inside {dsteq_pkg::OP_INSERT, dsteq_pkg::OP_POP}) begin
                  wq_in = req_chan.queue_select;
               end else begin
                  wq_in = 1'b0;
               end
               if (op_in == dsteq_pkg::OP_INSERT) begin
                  if (free_first_ff == NIL) begin
                     res_status_in = dsteq_pkg::STAT_POOL_EMPTY;
                     state_in      = dsteq_pkg::S_DONE;
                  end else begin
                     state_in = dsteq_pkg::S_INS_FREE;
                  end
               end else begin
                  state_in = dsteq_pkg::S_HEAD;
               end
            end
         end

         // fetch the link of the free head
         dsteq_pkg::S_INS_FREE: begin
            mem_rd_addr = free_first_ff[ADDR_W-1:0];
            new_in      = free_first_ff;
            state_in    = dsteq_pkg::S_INS_LINK;
         end

         // unlink the new entry from the free list, start at the queue head
         dsteq_pkg::S_INS_LINK: begin
            free_first_in = mem_rd_link;
            prev_in       = NIL;
            cur_in        = head_q;
            mem_rd_addr   = head_q[ADDR_W-1:0];
            state_in      = (head_q == NIL) ? dsteq_pkg::S_INS_PLACE : dsteq_pkg::S_INS_WALK;
         end

         // step past every entry with an equal or earlier wake time
         dsteq_pkg::S_INS_WALK: begin
            cmp_mode = dsteq_pkg::CMP_TIME_GE;
            if (cmp_hit) begin
               prev_in     = cur_ff;
               cur_in      = mem_rd_link;
               mem_rd_addr = mem_rd_link[ADDR_W-1:0];
               if (mem_rd_link == NIL) begin
                  state_in = dsteq_pkg::S_INS_PLACE;
               end
            end else begin
               state_in = dsteq_pkg::S_INS_PLACE;
            end
         end

         // new entry points at the first later entry
         dsteq_pkg::S_INS_PLACE: begin
            mem_wr      = '{en: 1'b1, all: 1'b1};
            mem_wr_addr = new_ff[ADDR_W-1:0];
            mem_wr_link = cur_ff;
            state_in    = dsteq_pkg::S_INS_FIX;
         end

         // predecessor or queue head points at the new entry
         dsteq_pkg::S_INS_FIX: begin
            if (prev_ff != NIL) begin
               mem_wr      = '{en: 1'b1, all: 1'b0};
               mem_wr_addr = prev_ff[ADDR_W-1:0];
               mem_wr_link = new_ff;
            end else begin
               head_wr  = 1'b1;
               head_val = new_ff;
            end
            state_in = dsteq_pkg::S_DONE;
         end

         // start of a walk for pop, remove and clear
         dsteq_pkg::S_HEAD: begin
            cur_in      = head_q;
            prev_in     = NIL;
            mem_rd_addr = head_q[ADDR_W-1:0];
            if (head_q == NIL) begin
               if (op_ff == dsteq_pkg::OP_POP) begin
                  res_status_in = dsteq_pkg::STAT_QUEUE_EMPTY;
                  state_in      = dsteq_pkg::S_DONE;
               end else if (!wq_ff) begin
                  wq_in = 1'b1;
               end else begin
                  res_status_in = end_status;
                  state_in      = dsteq_pkg::S_DONE;
               end
            end else begin
               case (op_ff)
                  dsteq_pkg::OP_POP:    state_in = dsteq_pkg::S_POP_TAKE;
                  dsteq_pkg::OP_REMOVE: state_in = dsteq_pkg::S_REM_WALK;
                  dsteq_pkg::OP_CLEAR:  state_in = dsteq_pkg::S_CLR_TAKE;
                  default:              state_in = dsteq_pkg::S_DONE;
               endcase
            end
         end

         // head entry goes back to the free list, its contents to the result
         dsteq_pkg::S_POP_TAKE: begin
            head_wr       = 1'b1;
            head_val      = mem_rd_link;
            mem_wr        = '{en: 1'b1, all: 1'b0};
            free_first_in = cur_ff;
            res_task_in   = OUT_TASK_W'(mem_rd_task);
            res_time_in   = mem_rd_time;
            state_in      = dsteq_pkg::S_DONE;
         end

         // look for the first entry with the task id
         dsteq_pkg::S_REM_WALK: begin
            cmp_mode = dsteq_pkg::CMP_TASK_EQ;
            if (cmp_hit) begin
               next_in  = mem_rd_link;
               found_in = 1'b1;
               state_in = dsteq_pkg::S_REM_UNLINK;
            end else begin
               prev_in     = cur_ff;
               cur_in      = mem_rd_link;
               mem_rd_addr = mem_rd_link[ADDR_W-1:0];
               if (mem_rd_link == NIL) begin
                  if (!wq_ff) begin
                     wq_in    = 1'b1;
                     state_in = dsteq_pkg::S_HEAD;
                  end else begin
                     res_status_in = end_status;
                     state_in      = dsteq_pkg::S_DONE;
                  end
               end
            end
         end

         // bypass the matched entry
         dsteq_pkg::S_REM_UNLINK: begin
            if (prev_ff != NIL) begin
               mem_wr      = '{en: 1'b1, all: 1'b0};
               mem_wr_addr = prev_ff[ADDR_W-1:0];
               mem_wr_link = next_ff;
            end else begin
               head_wr  = 1'b1;
               head_val = next_ff;
            end
            state_in = dsteq_pkg::S_REM_FREE;
         end

         // matched entry onto the free list, then on to the sync queue or to done
         dsteq_pkg::S_REM_FREE: begin
            mem_wr        = '{en: 1'b1, all: 1'b0};
            free_first_in = cur_ff;
            if (!wq_ff) begin
               wq_in    = 1'b1;
               state_in = dsteq_pkg::S_HEAD;
            end else begin
               res_status_in = end_status;
               state_in      = dsteq_pkg::S_DONE;
            end
         end

         // one entry per cycle: free the head while fetching its successor
         dsteq_pkg::S_CLR_TAKE: begin
            head_wr       = 1'b1;
            head_val      = mem_rd_link;
            mem_wr        = '{en: 1'b1, all: 1'b0};
            free_first_in = cur_ff;
            cur_in        = mem_rd_link;
            mem_rd_addr   = mem_rd_link[ADDR_W-1:0];
            if (mem_rd_link == NIL) begin
               if (!wq_ff) begin
                  wq_in    = 1'b1;
                  state_in = dsteq_pkg::S_HEAD;
               end else begin
                  state_in = dsteq_pkg::S_DONE;
               end
            end
         end

         // hand the result to the output register once it is free
         dsteq_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_task_in   = res_task_ff;
               rsp_time_in   = res_time_ff;
               state_in      = dsteq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = dsteq_pkg::S_IDLE;
         end
      endcase

      sleep_first_in = sleep_first_ff;
      sync_first_in  = sync_first_ff;
      if (head_wr) begin
         if (wq_ff) begin
            sync_first_in = head_val;
         end else begin
            sleep_first_in = head_val;
         end
      end
   end

   // a finished result reaches the output register on the next edge when that register is empty
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsteq_pkg::S_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not delivered from done state");

   // insert into an exhausted pool goes straight to done with pool empty
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.opcode == dsteq_pkg::OP_INSERT && free_first_ff == NIL)
      |=> (state_ff == dsteq_pkg::S_DONE && res_status_ff == dsteq_pkg::STAT_POOL_EMPTY))
      else $error("insert on exhausted pool not rejected");

   // no entry heads two lists at once
   assert property (@(posedge clock) disable iff (reset)
      !((free_first_ff != NIL) &&
        (free_first_ff == sleep_first_ff || free_first_ff == sync_first_ff)) &&
      !((sleep_first_ff != NIL) && (sleep_first_ff == sync_first_ff)))
      else $error("entry shared between list heads");

   // a response never changes while it waits to be taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_time_ff) && $stable(rsp_task_ff))
      else $error("pending response overwritten");

endmodule
